/* rtl/pma_pkg.sv */
// ----------------------------------------------------------------------------
// pma_pkg
// Shared types, constants and helper functions of the pressure meter with
// alarm and multiplexed seven-segment display.
// ----------------------------------------------------------------------------
`default_nettype none

package pma_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int OFFSET_W    = 32;
  localparam int SLOPE_W     = 24;
  localparam int THRESH_W    = 14;
  localparam int BLINK_W     = 8;
  localparam int PRESS_W     = 14;
  localparam int FRAC_W      = 16;
  localparam int SEG_W       = 7;
  localparam int SEL_W       = 3;
  localparam int POS_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 32'd591005876;
  localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 24'd627339;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd3000;
  localparam logic [BLINK_W-1:0]  BLINK_RESET  = 8'd10;

  localparam logic [PRESS_W-1:0] PRESSURE_MAX = 14'd9999;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK  = 2'd3;

  localparam logic [POS_W-1:0] POS_THOUSANDS = 3'd1;
  localparam logic [POS_W-1:0] POS_HUNDREDS  = 3'd2;
  localparam logic [POS_W-1:0] POS_TENS      = 3'd3;

  localparam logic [SEL_W-1:0] SEL_THOUSANDS = 3'b001;
  localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 3'b010;
  localparam logic [SEL_W-1:0] SEL_TENS      = 3'b100;
  localparam logic [SEL_W-1:0] SEL_NONE      = 3'b000;
  localparam logic [SEL_W-1:0] SEL_RESET     = 3'b111;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;
  } pma_in_t;

  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic [SEL_W-1:0]   digit_select;
    logic               led_ok;
    logic               led_fault;
    logic               buzzer;
    logic [PRESS_W-1:0] pressure_tenths;
  } pma_out_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_q16;
    logic [SLOPE_W-1:0]  slope_q16;
    logic [THRESH_W-1:0] alarm_threshold_tenths;
    logic [BLINK_W-1:0]  blink_wraps;
  } pma_cfg_t;

  // reciprocal multiplies, exact for any 14-bit value
  function automatic logic [10:0] div10(input logic [PRESS_W-1:0] p);
    logic [29:0] t;
    t = 30'(p) * 30'd52429;
    return t[29:19];
  endfunction

  function automatic logic [7:0] div100(input logic [PRESS_W-1:0] p);
    logic [29:0] t;
    t = 30'(p) * 30'd41944;
    return t[29:22];
  endfunction

  function automatic logic [4:0] div1000(input logic [PRESS_W-1:0] p);
    logic [27:0] t;
    t = 28'(p) * 28'd8389;
    return t[27:23];
  endfunction

  function automatic logic [3:0] digit_of(input logic [10:0] lo, input logic [10:0] hi);
    logic [10:0] d;
    d = lo - ((hi << 3) + (hi << 1));
    return d[3:0];
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] s;
    case (digit)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/pressure_meter_alarm_display.sv */
// ----------------------------------------------------------------------------
// pressure_meter_alarm_display
// Pressure meter with alarm and a three-digit multiplexed seven-segment scan.
//
// Input channel item_valid/item_stall/item carries one word per event: a
// converter sample (op sample) or a display scan tick (op tick). Every
// accepted word gives exactly one word on result_valid/result_stall/result,
// showing segments, digit enables, leds, buzzer and stored pressure after
// that event.
// A word goes into the input register, then the conversion or scan logic
// updates the meter state and loads the result register. Throughput is one
// word per cycle while the receiver does not stall, set by the single
// state-update step between those two registers.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more word; item_stall rises only when
// both are full.
// Configuration is a plain write port (wr_en, wr_index, wr_data).
// Synchronous reset loads the default calibration and clears the state.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_meter_alarm_display (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire pma_pkg::pma_in_t               item,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output pma_pkg::pma_out_t                   result,
  input  wire logic                           wr_en,
  input  wire logic [pma_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [pma_pkg::CFG_DATA_W-1:0] wr_data
);
  import pma_pkg::*;

  pma_cfg_t cfg;
  pma_in_t  stage_data;
  pma_out_t result_next;
  logic     stage_valid;
  logic     advance;
  logic     fire;

  assign advance = ~result_valid | ~result_stall;
  assign fire    = stage_valid & advance;

  pma_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  pma_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  pma_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage_data  (stage_data),
    .fire        (fire),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/pma_cfg.sv */
// ----------------------------------------------------------------------------
// pma_cfg
// Configuration register file: offset, slope, alarm threshold, blink wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [pma_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [pma_pkg::CFG_DATA_W-1:0]   wr_data,
  output pma_pkg::pma_cfg_t                     cfg
);
  import pma_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_q16             <= OFFSET_RESET;
      cfg.slope_q16              <= SLOPE_RESET;
      cfg.alarm_threshold_tenths <= THRESH_RESET;
      cfg.blink_wraps            <= BLINK_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_OFFSET: cfg.offset_q16             <= wr_data[OFFSET_W-1:0];
        REG_SLOPE:  cfg.slope_q16              <= wr_data[SLOPE_W-1:0];
        REG_THRESH: cfg.alarm_threshold_tenths <= wr_data[THRESH_W-1:0];
        REG_BLINK:  cfg.blink_wraps            <= wr_data[BLINK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/pma_in_stage.sv */
// ----------------------------------------------------------------------------
// pma_in_stage
// Input register: holds one accepted word while the result side is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire pma_pkg::pma_in_t  item,
  input  wire logic              advance,
  output logic                   stage_valid,
  output pma_pkg::pma_in_t       stage_data
);
  import pma_pkg::*;

  assign item_stall = stage_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      stage_data <= item;
    end
  end

endmodule

`default_nettype wire

/* rtl/pma_core.sv */
// ----------------------------------------------------------------------------
// pma_core
// Meter state and next-state logic: sample conversion with alarm compare,
// display scan with digit extraction and buzzer blink.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pma_pkg::pma_cfg_t cfg,
  input  wire pma_pkg::pma_in_t  stage_data,
  input  wire logic              fire,
  output pma_pkg::pma_out_t      result_next
);
  import pma_pkg::*;

  localparam int PROD_W = SLOPE_W + SAMPLE_BITS;
  localparam int DIFF_W = PROD_W + 1;

  logic [PRESS_W-1:0] pressure_reg, pressure_reg_next;
  logic               fault_flag, fault_flag_next;
  logic [POS_W-1:0]   scan_position, scan_position_next;
  logic [BLINK_W-1:0] wrap_count, wrap_count_next;
  logic               buzzer_level, buzzer_level_next;
  logic [SEG_W-1:0]   segment_reg, segment_reg_next;
  logic [SEL_W-1:0]   select_reg, select_reg_next;

  logic [PROD_W-1:0]   prod;
  logic [DIFF_W-1:0]   diff;
  logic [OFFSET_W-1:0] q;
  logic [OFFSET_W-1:0] thr;
  logic [FRAC_W-1:0]   whole;
  logic [POS_W-1:0]    pos;
  logic [BLINK_W:0]    wrap_inc;
  logic [10:0]         lo;
  logic [10:0]         hi;

  always_comb begin
    prod  = PROD_W'(cfg.slope_q16) * PROD_W'(stage_data.sample);
    diff  = DIFF_W'(cfg.offset_q16) - DIFF_W'(prod);
    q     = diff[DIFF_W-1] ? '0 : diff[OFFSET_W-1:0];
    thr   = OFFSET_W'({cfg.alarm_threshold_tenths, {FRAC_W{1'b0}}});
    whole = q[OFFSET_W-1:FRAC_W];

    pressure_reg_next  = pressure_reg;
    fault_flag_next    = fault_flag;
    scan_position_next = scan_position;
    wrap_count_next    = wrap_count;
    buzzer_level_next  = buzzer_level;
    segment_reg_next   = segment_reg;
    select_reg_next    = select_reg;
    pos                = scan_position;
    wrap_inc           = {1'b0, wrap_count} + 1'b1;
    lo                 = '0;
    hi                 = '0;

    if (stage_data.op == OP_SAMPLE) begin
      if (q > thr) begin
        fault_flag_next = 1'b1;
      end else if (q < thr) begin
        fault_flag_next   = 1'b0;
        buzzer_level_next = 1'b0;
      end
      pressure_reg_next = (whole > FRAC_W'(PRESSURE_MAX)) ? PRESSURE_MAX
                                                          : whole[PRESS_W-1:0];
    end else begin
      // scan wrap
      if (scan_position > POS_TENS) begin
        pos = POS_THOUSANDS;
        if (fault_flag) begin
          if (wrap_inc > {1'b0, cfg.blink_wraps}) begin
            wrap_count_next   = '0;
            buzzer_level_next = ~buzzer_level;
          end else begin
            wrap_count_next = wrap_inc[BLINK_W-1:0];
          end
        end else begin
          wrap_count_next   = '0;
          buzzer_level_next = 1'b0;
        end
      end
      case (pos)
        POS_THOUSANDS: begin
          lo               = 11'(div1000(pressure_reg));
          select_reg_next  = SEL_THOUSANDS;
          segment_reg_next = seg_of(digit_of(lo, hi));
        end
        POS_HUNDREDS: begin
          lo               = 11'(div100(pressure_reg));
          hi               = 11'(div1000(pressure_reg));
          select_reg_next  = SEL_HUNDREDS;
          segment_reg_next = seg_of(digit_of(lo, hi));
        end
        POS_TENS: begin
          lo               = div10(pressure_reg);
          hi               = 11'(div100(pressure_reg));
          select_reg_next  = SEL_TENS;
          segment_reg_next = seg_of(digit_of(lo, hi));
        end
        default: begin
          select_reg_next = SEL_NONE;
        end
      endcase
      scan_position_next = pos + 1'b1;
    end

    result_next.segments        = segment_reg_next;
    result_next.digit_select    = select_reg_next;
    result_next.led_ok          = ~fault_flag_next;
    result_next.led_fault       = fault_flag_next;
    result_next.buzzer          = buzzer_level_next;
    result_next.pressure_tenths = pressure_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_reg  <= '0;
      fault_flag    <= 1'b0;
      scan_position <= POS_THOUSANDS;
      wrap_count    <= '0;
      buzzer_level  <= 1'b0;
      segment_reg   <= '0;
      select_reg    <= SEL_RESET;
    end else if (fire) begin
      pressure_reg  <= pressure_reg_next;
      fault_flag    <= fault_flag_next;
      scan_position <= scan_position_next;
      wrap_count    <= wrap_count_next;
      buzzer_level  <= buzzer_level_next;
      segment_reg   <= segment_reg_next;
      select_reg    <= select_reg_next;
    end
  end

endmodule

`default_nettype wire

/* test/pressure_meter_alarm_display_tb.sv */
// ----------------------------------------------------------------------------
// pressure_meter_alarm_display_tb
// Self-checking bench for the pressure meter with alarm and seven-segment scan.
// A scoreboard object keeps its own copy of the calibration and the meter
// state, predicts the result word of every accepted input word and compares
// the result words in order. The run moves through several calibration sets
// with random idling on both sides and two long receiver hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_meter_alarm_display_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pma_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  class meter_scoreboard;
    logic [OFFSET_W-1:0] offset;
    logic [SLOPE_W-1:0]  slope;
    logic [THRESH_W-1:0] thresh;
    logic [BLINK_W-1:0]  blink;

    logic [PRESS_W-1:0] pressure;
    logic               fault;
    logic [POS_W-1:0]   scan_pos;
    logic [BLINK_W-1:0] wraps;
    logic               buzz;
    logic [SEG_W-1:0]   segs;
    logic [SEL_W-1:0]   sel;

    pma_out_t expected_q[$];
    int failures;
    int samples;
    int ticks;
    int toggles;
    int fault_raises;

    function new();
      offset   = OFFSET_RESET;
      slope    = SLOPE_RESET;
      thresh   = THRESH_RESET;
      blink    = BLINK_RESET;
      pressure = '0;
      fault    = 1'b0;
      scan_pos = POS_THOUSANDS;
      wraps    = '0;
      buzz     = 1'b0;
      segs     = '0;
      sel      = SEL_RESET;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OFFSET: offset = data[OFFSET_W-1:0];
        REG_SLOPE:  slope  = data[SLOPE_W-1:0];
        REG_THRESH: thresh = data[THRESH_W-1:0];
        REG_BLINK:  blink  = data[BLINK_W-1:0];
        default: ;
      endcase
    endfunction

    function void convert(logic [SAMPLE_BITS-1:0] s);
      longint q;
      longint lim;
      longint o;
      longint k;
      longint c;
      o = offset;
      k = slope;
      c = s;
      q = o - k * c;
      if (q <= 0) q = 0;
      lim = thresh;
      lim = lim * 65536;
      if (q > lim) begin
        if (!fault) fault_raises++;
        fault = 1'b1;
      end else if (q < lim) begin
        fault = 1'b0;
        buzz  = 1'b0;
      end
      q = q >>> FRAC_W;
      pressure = (q > 9999) ? PRESSURE_MAX : q[PRESS_W-1:0];
    endfunction

    function void scan();
      int next;
      if (scan_pos > POS_TENS) begin
        scan_pos = POS_THOUSANDS;
        if (fault) begin
          next = int'(wraps) + 1;
          if (next > int'(blink)) begin
            wraps = '0;
            buzz  = ~buzz;
            toggles++;
          end else begin
            wraps = next[BLINK_W-1:0];
          end
        end else begin
          wraps = '0;
          buzz  = 1'b0;
        end
      end
      case (scan_pos)
        POS_THOUSANDS: begin
          sel  = SEL_THOUSANDS;
          segs = DIGIT_SEGS[(pressure / 1000) % 10];
        end
        POS_HUNDREDS: begin
          sel  = SEL_HUNDREDS;
          segs = DIGIT_SEGS[(pressure / 100) % 10];
        end
        POS_TENS: begin
          sel  = SEL_TENS;
          segs = DIGIT_SEGS[(pressure / 10) % 10];
        end
        default: sel = SEL_NONE;
      endcase
      scan_pos = scan_pos + 1'b1;
    endfunction

    function void note_word(pma_in_t w);
      pma_out_t e;
      if (w.op == OP_SAMPLE) begin
        convert(w.sample);
        samples++;
      end else begin
        scan();
        ticks++;
      end
      e.segments        = segs;
      e.digit_select    = sel;
      e.led_ok          = ~fault;
      e.led_fault       = fault;
      e.buzzer          = buzz;
      e.pressure_tenths = pressure;
      expected_q.push_back(e);
    endfunction

    function void check_word(pma_out_t got);
      pma_out_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      if (got.segments !== e.segments) begin
        $error("segments: expected %h, got %h", e.segments, got.segments);
        failures++;
      end
      if (got.digit_select !== e.digit_select) begin
        $error("digit_select: expected %b, got %b", e.digit_select, got.digit_select);
        failures++;
      end
      if (got.led_ok !== e.led_ok) begin
        $error("led_ok: expected %b, got %b", e.led_ok, got.led_ok);
        failures++;
      end
      if (got.led_fault !== e.led_fault) begin
        $error("led_fault: expected %b, got %b", e.led_fault, got.led_fault);
        failures++;
      end
      if (got.buzzer !== e.buzzer) begin
        $error("buzzer: expected %b, got %b", e.buzzer, got.buzzer);
        failures++;
      end
      if (got.pressure_tenths !== e.pressure_tenths) begin
        $error("pressure_tenths: expected %0d, got %0d", e.pressure_tenths,
               got.pressure_tenths);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic     item_valid = 1'b0;
  logic     item_stall;
  pma_in_t  item_word = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  pma_out_t result_word;

  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  meter_scoreboard sb = new();
  int cycle_count = 0;
  int tx_burst_left = 0;
  int settings_used = 0;

  pressure_meter_alarm_display i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic calibrate(logic [31:0] off, logic [31:0] slp, logic [31:0] thr,
                           logic [31:0] blk);
    write_reg(REG_OFFSET, off);
    write_reg(REG_SLOPE, slp);
    write_reg(REG_THRESH, thr);
    write_reg(REG_BLINK, blk);
    settings_used++;
  endtask

  task automatic send_word(logic op, logic [SAMPLE_BITS-1:0] s);
    int gap;
    pma_in_t w;
    w.op     = op;
    w.sample = s;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 29) == 0) tx_burst_left = $urandom_range(10, 40);
    end
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item_word  <= w;
    do @(posedge clk); while (item_stall);
    sb.note_word(w);
  endtask

  // drain and let the pipeline settle before touching the calibration
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_words(int count, int tick_pct, int near_lo, int near_hi,
                              int near_pct);
    logic op;
    logic [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SAMPLE;
      if ($urandom_range(0, 99) < near_pct) begin
        s = SAMPLE_BITS'($urandom_range(near_lo, near_hi));
      end else begin
        s = SAMPLE_BITS'($urandom_range(0, 1023));
      end
      send_word(op, s);
    end
  endtask

  // receiver: random stalls, bursts without stalls, two long hold-offs
  initial begin : receiver
    int stall_cycles;
    int taken;
    int rx_burst_left;
    taken = 0;
    rx_burst_left = 0;
    forever begin
      if (taken == 400 || taken == 950) begin
        stall_cycles = HOLD_CYCLES;
      end else if (rx_burst_left > 0) begin
        rx_burst_left--;
        stall_cycles = 0;
      end else begin
        stall_cycles = $urandom_range(0, 5);
        if ($urandom_range(0, 29) == 0) rx_burst_left = $urandom_range(10, 40);
      end
      if (stall_cycles > 0) begin
        @(negedge clk);
        result_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!result_valid);
      sb.check_word(result_word);
      taken++;
    end
  end

  initial begin : stimulus
    logic [31:0] off;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // reset calibration: full scale, negative clamp, digit scan and wrap
    settings_used++;
    send_word(OP_SAMPLE, 10'd0);
    repeat (5) send_word(OP_TICK, 10'h3FF);
    send_word(OP_SAMPLE, 10'h3FF);
    send_word(OP_TICK, 10'h000);
    send_word(OP_SAMPLE, 10'h155);
    repeat (4) send_word(OP_TICK, 10'h2AA);
    send_word(OP_SAMPLE, 10'h2AA);
    repeat (4) send_word(OP_TICK, 10'h155);
    send_word(OP_SAMPLE, 10'h200);
    send_word(OP_TICK, 10'h0);
    drain();

    // sample 512 lands exactly on the threshold
    calibrate(32'd230162432, 32'd65536, 32'd3000, 32'd1);
    send_word(OP_SAMPLE, 10'd512);
    send_word(OP_SAMPLE, 10'd511);
    send_word(OP_SAMPLE, 10'd512);
    repeat (12) send_word(OP_TICK, 10'd0);
    send_word(OP_SAMPLE, 10'd513);
    send_word(OP_SAMPLE, 10'd512);
    repeat (4) send_word(OP_TICK, 10'd0);
    random_words(240, 50, 505, 519, 70);
    drain();

    // saturated pressure with the longest blink count, mostly ticks
    calibrate(32'hFFFF_FFFF, 32'd0, 32'd9999, 32'd255);
    random_words(850, 95, 0, 1023, 0);
    drain();

    // zero pressure against a zero threshold keeps the fault where it is
    calibrate(32'd0, 32'hFF_FFFF, 32'd0, 32'd1);
    random_words(100, 50, 0, 1023, 0);
    drain();

    for (int k = 0; k < 3; k++) begin
      off = $urandom();
      calibrate(off, $urandom_range(0, 24'hFF_FFFF) >> $urandom_range(4, 12),
                $urandom_range(0, 9999), $urandom_range(1, 3));
      random_words(80, 55, 0, 1023, 0);
      drain();
    end

    repeat (10) @(negedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d result words never arrived", sb.expected_q.size());
      sb.failures++;
    end
    $display("covered %0d samples and %0d scan ticks over %0d calibration sets",
             sb.samples, sb.ticks, settings_used);
    $display("fault raised %0d times, buzzer toggled %0d times, %0d mismatches",
             sb.fault_raises, sb.toggles, sb.failures);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/pma_pkg.sv
rtl/pma_cfg.sv
rtl/pma_in_stage.sv
rtl/pma_core.sv
rtl/pressure_meter_alarm_display.sv
test/pressure_meter_alarm_display_tb.sv
